// ===== hw/rtl/task_period_jitter_monitor_macros.svh =====
// assertion macros for the period jitter monitor
// used by the top level, no other dependencies
`ifndef TASK_PERIOD_JITTER_MONITOR_MACROS_SVH
`define TASK_PERIOD_JITTER_MONITOR_MACROS_SVH

// same-cycle implication
`define TPJM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpjm assertion failed");

// next-cycle implication
`define TPJM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpjm assertion failed");

`endif

// ===== hw/rtl/tpjm_pkg.sv =====
// shared types and constants of the period jitter monitor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tpjm_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned SUM_W    = 48;
   localparam int unsigned TOL_W    = 10;
   localparam int unsigned NUM_EXP  = 6;
   localparam int unsigned NUM_REGS = 7;
   localparam int unsigned IDX_W    = 3;
   localparam int unsigned CHAN_W   = 3;
   localparam int unsigned PERMILLE = 1000;

   localparam logic [IDX_W-1:0] REG_TOL = 3'd6;
   localparam logic [TOL_W-1:0] TOL_RESET = 10'd50;
   localparam logic [DATA_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

   localparam logic [DATA_W-1:0] EXP_RESET [NUM_EXP] = '{
      32'd1000, 32'd100000, 32'd1000000, 32'd100000, 32'd100000, 32'd1000000
   };

   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_REPORT = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIV1,
      S_MUL,
      S_DIV2,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] count;
      logic [SUM_W-1:0]  sum;
      logic [DATA_W-1:0] min;
      logic [DATA_W-1:0] max;
   } stat_type;

   localparam stat_type STAT_RESET = '{
      count: '0, sum: '0, min: '1, max: '0
   };

endpackage

`default_nettype wire

// ===== hw/rtl/tpjm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tpjm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tpjm_div.sv =====
// restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module tpjm_div #(
   parameter int unsigned NUM_W = 48,
   parameter int unsigned DEN_W = 32,
   localparam int unsigned CNT_W = $clog2(NUM_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [DEN_W:0]   shifted, trial;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/task_period_jitter_monitor.sv =====
// start event on an in-range channel: accepted, then one ram read-modify-write; ready again after the write in S_READ
// report: with no data it goes from the ram read straight to the output register, else
// the one-bit-per-cycle divider runs twice (average, then per-mille error)
// one transaction in flight; a finished report waits in the output register
// reset (synchronous, active high): idle, channel valid bits cleared so every
// channel reads as empty, period and tolerance registers back to defaults
`timescale 1ns / 1ps
`default_nettype none
`include "task_period_jitter_monitor_macros.svh"

module task_period_jitter_monitor #(
   parameter int unsigned NUM_CHANNELS = 6,
   parameter int unsigned TIME_BITS    = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // channel [2:0], timestamp_us [34:3]
   input  wire logic [39:0]  req_tdata,
   // req_type [1:0]
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // report_channel [2:0], no_data [3], min_interval [35:4], max_interval [67:36],
   // jitter [99:68], average_interval [131:100], error_permille [163:132],
   // within_tolerance [164]
   output logic      [167:0] rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   localparam int unsigned CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int unsigned STAT_W = $bits(tpjm_pkg::stat_type);
   localparam int unsigned WORD_W = STAT_W + TIME_BITS;
   localparam int unsigned DT_W   = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int unsigned DW     = tpjm_pkg::DATA_W;
   localparam int unsigned SW     = tpjm_pkg::SUM_W;

   tpjm_pkg::state_type state_ff, state_in;

   logic [DW-1:0]           exp_reg_ff [tpjm_pkg::NUM_EXP];
   logic [tpjm_pkg::TOL_W-1:0] tol_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;

   tpjm_pkg::req_type_type  type_ff;
   logic [2:0]              chan_ff;
   logic [CH_W-1:0]         idx_ff;
   logic [DW-1:0]           ts_ff;
   logic                    inrange_ff;
   logic [DW-1:0]           min_ff, max_ff, exp_ff, ave_ff, diff_ff, err_ff;
   logic                    nodata_ff, within_ff;
   logic                    rsp_valid_ff;
   logic [167:0]            rsp_data_ff;

   logic                    req_fire, in_range;
   logic [2:0]              req_chan;
   tpjm_pkg::req_type_type  req_kind;
   logic [CH_W-1:0]         rd_idx;
   logic                    ram_we, div_start, div_done, rsp_load;
   logic [SW-1:0]           div_num, quotient;
   logic [DW-1:0]           div_den;
   logic [WORD_W-1:0]       rd_word, wr_word;
   tpjm_pkg::stat_type      rd_stat, wr_stat;
   logic [TIME_BITS-1:0]    rd_last, t_now, dt_full;
   logic [DT_W-1:0]         dt_ext;
   logic [DW-1:0]           dt32, ave_sat, err_sat, exp_sel;
   logic [SW:0]             sum_add;
   logic [41:0]             prod;
   logic [2:0]              exp_idx;

   assign req_fire = req_tvalid && req_tready;
   assign req_chan = req_tdata[2:0];
   assign req_kind = tpjm_pkg::req_type_type'(req_tuser);
   assign in_range = 5'(req_chan) < 5'(NUM_CHANNELS);
   assign rd_idx   = in_range ? CH_W'(req_chan) : '0;
   assign req_tready = (state_ff == tpjm_pkg::S_IDLE);

   tpjm_ram #(.WIDTH(WORD_W), .DEPTH(NUM_CHANNELS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff),
      .wdata (wr_word),
      .raddr (rd_idx),
      .rdata (rd_word)
   );

   tpjm_div #(.NUM_W(SW), .DEN_W(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (quotient)
   );

   // entries not written since reset or clear read as empty
   always_comb begin
      if (valid_ff[idx_ff]) begin
         rd_stat = tpjm_pkg::stat_type'(rd_word[WORD_W-1:TIME_BITS]);
         rd_last = rd_word[TIME_BITS-1:0];
      end else begin
         rd_stat = tpjm_pkg::STAT_RESET;
         rd_last = '0;
      end
   end

   // event update
   always_comb begin
      t_now   = TIME_BITS'(ts_ff);
      dt_full = t_now - rd_last;
      dt_ext  = DT_W'(dt_full);
      dt32    = (dt_ext > DT_W'(tpjm_pkg::CNT_MAX)) ? tpjm_pkg::CNT_MAX : dt_ext[DW-1:0];
      sum_add = {1'b0, rd_stat.sum} + (SW+1)'(dt32);
      wr_stat = rd_stat;
      if (rd_stat.count != '0) begin
         if (dt32 > rd_stat.max) wr_stat.max = dt32;
         if (dt32 < rd_stat.min) wr_stat.min = dt32;
         wr_stat.sum = sum_add[SW] ? '1 : sum_add[SW-1:0];
      end
      if (rd_stat.count != tpjm_pkg::CNT_MAX) wr_stat.count = rd_stat.count + 1'b1;
      wr_word = {wr_stat, t_now};
   end

   assign exp_idx = (chan_ff < 3'd6) ? chan_ff : 3'd5;
   assign exp_sel = (exp_reg_ff[exp_idx] == '0) ? DW'(1) : exp_reg_ff[exp_idx];
   assign ave_sat = (|quotient[SW-1:DW]) ? tpjm_pkg::CNT_MAX : quotient[DW-1:0];
   assign err_sat = ave_sat;
   assign prod    = {10'b0, diff_ff} * 42'(tpjm_pkg::PERMILLE);

   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         tpjm_pkg::S_IDLE: begin
            if (req_fire) begin
               if ((req_kind == tpjm_pkg::REQ_START && in_range) ||
                   req_kind == tpjm_pkg::REQ_REPORT) begin
                  state_in = tpjm_pkg::S_READ;
               end
            end
         end
         tpjm_pkg::S_READ: begin
            if (type_ff == tpjm_pkg::REQ_START) begin
               ram_we   = 1'b1;
               state_in = tpjm_pkg::S_IDLE;
            end else if (!inrange_ff || rd_stat.count < DW'(2)) begin
               state_in = tpjm_pkg::S_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = rd_stat.sum;
               div_den   = rd_stat.count - 1'b1;
               state_in  = tpjm_pkg::S_DIV1;
            end
         end
         tpjm_pkg::S_DIV1: begin
            if (div_done) state_in = tpjm_pkg::S_MUL;
         end
         tpjm_pkg::S_MUL: begin
            div_start = 1'b1;
            div_num   = SW'(prod);
            div_den   = exp_ff;
            state_in  = tpjm_pkg::S_DIV2;
         end
         tpjm_pkg::S_DIV2: begin
            if (div_done) state_in = tpjm_pkg::S_OUT;
         end
         tpjm_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = tpjm_pkg::S_IDLE;
            end
         end
         default: state_in = tpjm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpjm_pkg::S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= tpjm_pkg::TOL_RESET;
         for (int i = 0; i < tpjm_pkg::NUM_EXP; i++) exp_reg_ff[i] <= tpjm_pkg::EXP_RESET[i];
      end else begin
         state_ff <= state_in;
         if (req_fire && req_kind == tpjm_pkg::REQ_CLEAR) valid_ff <= '0;
         else if (ram_we) valid_ff[idx_ff] <= 1'b1;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            if (csr_index == tpjm_pkg::REG_TOL) tol_ff <= csr_wdata[tpjm_pkg::TOL_W-1:0];
            else if (csr_index < tpjm_pkg::REG_TOL) exp_reg_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff    <= req_kind;
         chan_ff    <= req_chan;
         idx_ff     <= rd_idx;
         ts_ff      <= req_tdata[34:3];
         inrange_ff <= in_range;
      end
      if (state_ff == tpjm_pkg::S_READ) begin
         nodata_ff <= !inrange_ff || rd_stat.count < DW'(2);
         min_ff    <= rd_stat.min;
         max_ff    <= rd_stat.max;
         exp_ff    <= exp_sel;
      end
      if (state_ff == tpjm_pkg::S_DIV1 && div_done) begin
         ave_ff  <= ave_sat;
         diff_ff <= (ave_sat >= exp_ff) ? ave_sat - exp_ff : exp_ff - ave_sat;
      end
      if (state_ff == tpjm_pkg::S_DIV2 && div_done) begin
         err_ff    <= err_sat;
         within_ff <= err_sat < DW'(tol_ff);
      end
      if (rsp_load) begin
         if (nodata_ff) begin
            rsp_data_ff <= {164'b0, 1'b1, chan_ff};
         end else begin
            rsp_data_ff <= {3'b0, within_ff, err_ff, ave_ff, max_ff - min_ff,
                            max_ff, min_ff, 1'b0, chan_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TPJM_ASSERT_IMPL(a_we_in_read, clock, reset, ram_we, state_ff == tpjm_pkg::S_READ)
   `TPJM_ASSERT_IMPL(a_done_in_div, clock, reset, div_done,
                     state_ff == tpjm_pkg::S_DIV1 || state_ff == tpjm_pkg::S_DIV2)
   `TPJM_ASSERT_NEXT(a_load_shows, clock, reset, rsp_load,
                     rsp_valid_ff && state_ff == tpjm_pkg::S_IDLE)
   `TPJM_ASSERT_IMPL(a_rise_from_out, clock, reset, $rose(rsp_valid_ff),
                     $past(state_ff) == tpjm_pkg::S_OUT)

endmodule

`default_nettype wire
